/* rtl/assert_macros.svh */
// Assertion helper macros for the CABAC encoder RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication check: when ante holds at a clock edge, cons must hold too.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

/* rtl/cabac_enc_pkg.sv */
// Shared types, constants and LPS range table for the CABAC encoder.
// No dependencies; imported by all CABAC encoder modules.
`default_nettype none

package cabac_enc_pkg;

  // Input mode codes
  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_REG   = 3'd1;
  localparam logic [2:0] MODE_BYP   = 3'd2;
  localparam logic [2:0] MODE_TERM  = 3'd3;
  localparam logic [2:0] MODE_FIN   = 3'd4;

  // Working low register: 12-bit entry value plus up to 8 doublings
  localparam int LOW_W = 20;

  localparam logic [8:0]  RANGE_RESET = 9'd510;
  localparam logic [8:0]  RANGE_TERM  = 9'd2;
  localparam logic [3:0]  BR_RESET    = 4'd9;
  localparam logic [3:0]  BYTE_BITS   = 4'd8;

  localparam logic [LOW_W-1:0] LOW_QTR  = LOW_W'(256);
  localparam logic [LOW_W-1:0] LOW_HALF = LOW_W'(512);
  localparam logic [LOW_W-1:0] LOW_FULL = LOW_W'(1024);

  // Result buffer
  localparam int RB_DEPTH = 34;
  localparam int RB_AW    = $clog2(RB_DEPTH);
  localparam int RB_CW    = $clog2(RB_DEPTH + 1);

  // Packer control from the sequencer
  typedef struct packed {
    logic clr;
    logic put;
    logic bit_val;
    logic flush;
  } pk_ctl_t;

  // Byte request from the packer into the result buffer
  typedef struct packed {
    logic       valid;
    logic [7:0] value;
    logic [3:0] count;
  } emit_t;

  // Result buffer control from the sequencer
  typedef struct packed {
    logic clr;
    logic start;
    logic ovf;
  } rb_ctl_t;

  // LPS range table, indexed [state][range quarter]
  localparam logic [7:0] LPS_TAB [64][4] = '{
    '{128,176,208,240}, '{128,167,197,227}, '{128,158,187,216}, '{123,150,178,205},
    '{116,142,169,195}, '{111,135,160,185}, '{105,128,152,175}, '{100,122,144,166},
    '{95,116,137,158},  '{90,110,130,150},  '{85,104,123,142},  '{81,99,117,135},
    '{77,94,111,128},   '{73,89,105,122},   '{69,85,100,116},   '{66,80,95,110},
    '{62,76,90,104},    '{59,72,86,99},     '{56,69,81,94},     '{53,65,77,89},
    '{51,62,73,85},     '{48,59,69,80},     '{46,56,66,76},     '{43,53,63,72},
    '{41,50,59,69},     '{39,48,56,65},     '{37,45,54,62},     '{35,43,51,59},
    '{33,41,48,56},     '{32,39,46,53},     '{30,37,43,50},     '{29,35,41,48},
    '{27,33,39,45},     '{26,31,37,43},     '{24,30,35,41},     '{23,28,33,39},
    '{22,27,32,37},     '{21,26,30,35},     '{20,24,29,33},     '{19,23,27,31},
    '{18,22,26,30},     '{17,21,25,28},     '{16,20,23,27},     '{15,19,22,25},
    '{14,18,21,24},     '{14,17,20,23},     '{13,16,19,22},     '{12,15,18,21},
    '{12,14,17,20},     '{11,14,16,19},     '{11,13,15,18},     '{10,12,15,17},
    '{10,12,14,16},     '{9,11,13,15},      '{9,11,12,14},      '{8,10,12,14},
    '{8,9,11,13},       '{7,9,11,12},       '{7,9,10,12},       '{7,8,10,11},
    '{6,8,9,11},        '{6,7,9,10},        '{6,7,8,9},         '{2,2,2,2}
  };

endpackage

`default_nettype wire

/* rtl/cabac_enc_pack.sv */
// Bit packer: shifts coded bits in MSB first and requests full or partial bytes.
// Depends on cabac_enc_pkg.
`default_nettype none

module cabac_enc_pack (
  input  wire                    clk,
  input  wire                    rst_n,
  input  cabac_enc_pkg::pk_ctl_t ctl,
  output cabac_enc_pkg::emit_t   emit
);
  import cabac_enc_pkg::*;

  logic [8:0] acc_r,  acc_nxt;
  logic [3:0] br_r,   br_nxt;
  logic [8:0] acc_sh;
  logic [3:0] part_n;
  logic [8:0] part_mask;
  logic [8:0] part_val;

  // 9 free slots at start: the first coded bit falls off the top
  assign acc_sh    = {acc_r[7:0], ctl.bit_val};
  assign part_n    = BYTE_BITS - br_r;
  assign part_mask = (9'd1 << part_n) - 9'd1;
  assign part_val  = acc_r & part_mask;

  always_comb begin
    acc_nxt    = acc_r;
    br_nxt     = br_r;
    emit.valid = 1'b0;
    emit.value = acc_sh[7:0];
    emit.count = BYTE_BITS;
    if (ctl.clr) begin
      acc_nxt = '0;
      br_nxt  = BR_RESET;
    end else if (ctl.put) begin
      if (br_r <= 4'd1) begin
        emit.valid = 1'b1;
        acc_nxt    = '0;
        br_nxt     = BYTE_BITS;
      end else begin
        acc_nxt = acc_sh;
        br_nxt  = br_r - 4'd1;
      end
    end else if (ctl.flush) begin
      emit.valid = (br_r < BYTE_BITS);
      emit.value = part_val[7:0];
      emit.count = part_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      br_r  <= BR_RESET;
    end else begin
      acc_r <= acc_nxt;
      br_r  <= br_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/cabac_enc_rbuf.sv */
// Result buffer: collects the bytes of one request, then drains them with last/overflow.
// Depends on cabac_enc_pkg.
`default_nettype none

module cabac_enc_rbuf (
  input  wire                    clk,
  input  wire                    rst_n,
  input  cabac_enc_pkg::rb_ctl_t ctl,
  input  cabac_enc_pkg::emit_t   emit,
  output logic                   busy,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [7:0]             out_byte_value,
  output logic [3:0]             out_bit_count,
  output logic                   out_last,
  output logic                   out_overflow
);
  import cabac_enc_pkg::*;

  logic [11:0]      mem [RB_DEPTH];
  logic [11:0]      rdata_r;
  logic [RB_CW-1:0] cnt_r;
  logic [RB_CW-1:0] rd_r;
  logic             drain_r;
  logic             pend_r;
  logic             ovf_r;
  logic             wr_en;
  logic             issue;
  logic             load;
  logic             take;

  // Bytes past the buffer depth are dropped
  assign wr_en = emit.valid && (cnt_r < RB_CW'(RB_DEPTH));
  assign take  = !out_valid || out_ready;
  assign issue = drain_r && !pend_r && (rd_r != cnt_r);
  assign load  = pend_r && take;
  assign busy  = drain_r && ((rd_r != cnt_r) || pend_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[RB_AW-1:0]] <= {emit.value, emit.count};
    end
    if (issue) begin
      rdata_r <= mem[rd_r[RB_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rd_r      <= '0;
      drain_r   <= 1'b0;
      pend_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.clr) begin
        cnt_r   <= '0;
        rd_r    <= '0;
        drain_r <= 1'b0;
        pend_r  <= 1'b0;
      end else begin
        if (wr_en) begin
          cnt_r <= cnt_r + RB_CW'(1);
        end
        if (ctl.start) begin
          drain_r <= 1'b1;
          ovf_r   <= ctl.ovf;
        end
        if (issue) begin
          rd_r   <= rd_r + RB_CW'(1);
          pend_r <= 1'b1;
        end else if (load) begin
          pend_r <= 1'b0;
        end
      end
      if (load) begin
        out_valid      <= 1'b1;
        out_byte_value <= rdata_r[11:4];
        out_bit_count  <= rdata_r[3:0];
        out_last       <= (rd_r == cnt_r);
        out_overflow   <= ovf_r;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/cabac_binary_arith_encoder_top.sv */
// CABAC binary arithmetic encoder top level: sequencer, low/range state, shared
// renormalization step unit. Depends on cabac_enc_pkg, cabac_enc_pack, cabac_enc_rbuf.
//
//   channel | ports                                          | dir
//   --------+------------------------------------------------+-----
//   in      | in_valid/in_ready, mode, bin, ctx_state, mps   | in
//   out     | out_valid/out_ready, byte_value, bit_count,    | out
//           | last, overflow                                 |
//
// Steps: a request is taken in S_IDLE. S_EXEC then sets up low/range (start and
// unused modes return to idle there); then S_RENORM shifts range and low until
// range is normalized, with a final range check, or S_BYP makes the bypass decision;
// S_FOLLOW emits outstanding bits, S_FIN1 to S_FIN3 finish, and S_DONE hands the
// bytes to the buffer. The shared step unit (compare, subtract, shift of the
// working low) and the one-bit-per-cycle packer do the work of these states.
// Result bytes drain from the buffer one at a time, each loaded into the output
// register before the next is read; the next request is taken once the last
// byte has been read into the output register. Reset is synchronous and needs no
// clearing pass. Output stalls hold the drain and the next request, never coder state.
`default_nettype none
`include "assert_macros.svh"

module cabac_binary_arith_encoder_top #(
  parameter int OUTSTANDING_WIDTH = 8
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [2:0] in_mode,
  input  wire        in_bin,
  input  wire  [5:0] in_ctx_state,
  input  wire        in_ctx_mps,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_byte_value,
  output logic [3:0] out_bit_count,
  output logic       out_last,
  output logic       out_overflow
);
  import cabac_enc_pkg::*;

  localparam logic [OUTSTANDING_WIDTH-1:0] OB_MAX = {OUTSTANDING_WIDTH{1'b1}};
  localparam logic [OUTSTANDING_WIDTH-1:0] OB_ONE = OUTSTANDING_WIDTH'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RENORM, S_BYP, S_FOLLOW, S_FIN1, S_FIN2, S_FIN3, S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  state_t                       ret_r,   ret_nxt;
  logic [2:0]                   mode_r,  mode_nxt;
  logic                         bin_r,   bin_nxt;
  logic [5:0]                   st_r,    st_nxt;
  logic                         mps_r,   mps_nxt;
  logic [10:0]                  low_r,   low_nxt;
  logic [8:0]                   range_r, range_nxt;
  logic [LOW_W-1:0]             wl_r,    wl_nxt;
  logic [OUTSTANDING_WIDTH-1:0] ob_r,    ob_nxt;
  logic                         ovf_r,   ovf_nxt;
  logic                         fb_r,    fb_nxt;

  pk_ctl_t pk_ctl;
  emit_t   emit;
  rb_ctl_t rb_ctl;
  logic    rb_busy;

  // Interval split
  logic [7:0]       lps;
  logic [8:0]       rmps;
  logic [8:0]       rterm;
  logic             lps_path;

  // Shared step unit: decide bit / outstanding, subtract, shift
  logic             is_byp;
  logic [LOW_W-1:0] thr_hi, thr_mid, amt, diff, diff_sh;
  logic             ge_hi, lt_mid, do_bump;

  assign lps      = LPS_TAB[st_r][range_r[7:6]];
  assign rmps     = range_r - {1'b0, lps};
  assign rterm    = range_r - RANGE_TERM;
  assign lps_path = (bin_r != mps_r);

  // Bypass compares the doubled low against doubled thresholds, no shift after
  assign is_byp  = (state_r == S_BYP);
  assign thr_hi  = is_byp ? LOW_FULL : LOW_HALF;
  assign thr_mid = is_byp ? LOW_HALF : LOW_QTR;
  assign ge_hi   = (wl_r >= thr_hi);
  assign lt_mid  = (wl_r < thr_mid);
  assign amt     = ge_hi ? thr_hi : (lt_mid ? '0 : thr_mid);
  assign diff    = wl_r - amt;
  assign diff_sh = {diff[LOW_W-2:0], 1'b0};

  assign in_ready = (state_r == S_IDLE) && !rb_busy;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    mode_nxt  = mode_r;
    bin_nxt   = bin_r;
    st_nxt    = st_r;
    mps_nxt   = mps_r;
    low_nxt   = low_r;
    range_nxt = range_r;
    wl_nxt    = wl_r;
    ob_nxt    = ob_r;
    ovf_nxt   = ovf_r;
    fb_nxt    = fb_r;
    pk_ctl    = '0;
    rb_ctl    = '0;
    do_bump   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          mode_nxt   = in_mode;
          bin_nxt    = in_bin;
          st_nxt     = in_ctx_state;
          mps_nxt    = in_ctx_mps;
          rb_ctl.clr = 1'b1;
          state_nxt  = S_EXEC;
        end
      end

      S_EXEC: begin
        case (mode_r)
          MODE_START: begin
            low_nxt    = '0;
            range_nxt  = RANGE_RESET;
            ob_nxt     = '0;
            ovf_nxt    = 1'b0;
            pk_ctl.clr = 1'b1;
            state_nxt  = S_IDLE;
          end
          MODE_REG: begin
            wl_nxt    = LOW_W'(low_r) + (lps_path ? LOW_W'(rmps) : '0);
            range_nxt = lps_path ? {1'b0, lps} : rmps;
            state_nxt = S_RENORM;
          end
          MODE_BYP: begin
            wl_nxt    = LOW_W'({low_r, 1'b0}) + (bin_r ? LOW_W'(range_r) : '0);
            state_nxt = S_BYP;
          end
          MODE_TERM: begin
            wl_nxt    = LOW_W'(low_r) + (bin_r ? LOW_W'(rterm) : '0);
            range_nxt = bin_r ? RANGE_TERM : rterm;
            state_nxt = S_RENORM;
          end
          MODE_FIN: begin
            state_nxt = S_FIN1;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_RENORM: begin
        if (range_r[8]) begin
          low_nxt   = wl_r[10:0];
          state_nxt = S_DONE;
        end else begin
          range_nxt = {range_r[7:0], 1'b0};
          wl_nxt    = diff_sh;
          if (ge_hi || lt_mid) begin
            pk_ctl.put     = 1'b1;
            pk_ctl.bit_val = ge_hi;
            fb_nxt         = ge_hi;
            ret_nxt        = S_RENORM;
            state_nxt      = (ob_r != '0) ? S_FOLLOW : S_RENORM;
          end else begin
            do_bump = 1'b1;
          end
        end
      end

      S_BYP: begin
        low_nxt = diff[10:0];
        if (ge_hi || lt_mid) begin
          pk_ctl.put     = 1'b1;
          pk_ctl.bit_val = ge_hi;
          fb_nxt         = ge_hi;
          ret_nxt        = S_DONE;
          state_nxt      = (ob_r != '0) ? S_FOLLOW : S_DONE;
        end else begin
          do_bump   = 1'b1;
          state_nxt = S_DONE;
        end
      end

      // Outstanding bits: inverse of the resolved bit, one per cycle
      S_FOLLOW: begin
        pk_ctl.put     = 1'b1;
        pk_ctl.bit_val = ~fb_r;
        ob_nxt         = ob_r - OB_ONE;
        if (ob_r == OB_ONE) begin
          state_nxt = ret_r;
        end
      end

      S_FIN1: begin
        pk_ctl.put     = 1'b1;
        pk_ctl.bit_val = low_r[9];
        fb_nxt         = low_r[9];
        ret_nxt        = S_FIN2;
        state_nxt      = (ob_r != '0) ? S_FOLLOW : S_FIN2;
      end

      S_FIN2: begin
        pk_ctl.put     = 1'b1;
        pk_ctl.bit_val = low_r[8];
        state_nxt      = S_FIN3;
      end

      S_FIN3: begin
        pk_ctl.flush = 1'b1;
        state_nxt    = S_DONE;
      end

      S_DONE: begin
        rb_ctl.start = 1'b1;
        rb_ctl.ovf   = ovf_r;
        state_nxt    = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Saturating outstanding counter with sticky overflow
    if (do_bump) begin
      if (ob_r == OB_MAX) begin
        ovf_nxt = 1'b1;
      end else begin
        ob_nxt = ob_r + OB_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_DONE;
      low_r   <= '0;
      range_r <= RANGE_RESET;
      ob_r    <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      low_r   <= low_nxt;
      range_r <= range_nxt;
      ob_r    <= ob_nxt;
      ovf_r   <= ovf_nxt;
    end
    mode_r <= mode_nxt;
    bin_r  <= bin_nxt;
    st_r   <= st_nxt;
    mps_r  <= mps_nxt;
    wl_r   <= wl_nxt;
    fb_r   <= fb_nxt;
  end

  cabac_enc_pack u_pack (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (pk_ctl),
    .emit (emit)
  );

  cabac_enc_rbuf u_rbuf (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (rb_ctl),
    .emit          (emit),
    .busy          (rb_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte_value(out_byte_value),
    .out_bit_count (out_bit_count),
    .out_last      (out_last),
    .out_overflow  (out_overflow)
  );

  // Range never collapses to zero, or renormalization would not end
  `ASSERT_NEVER(a_range_nonzero, clk, rst_n, range_r == '0)
  // Follower loop is only entered with bits pending
  `ASSERT_IMPL(a_follow_pending, clk, rst_n, state_r == S_FOLLOW, ob_r != '0)
  // No byte request outside request processing
  `ASSERT_NEVER(a_no_emit_idle, clk, rst_n, (state_r == S_IDLE) && emit.valid)

endmodule

`default_nettype wire
